// ===== hw/rtl/ags_pkg.sv =====
// ----------------------------------------------------------------------------
// ags_pkg
// Shared types and codes for the adjacency matrix graph store: vertex and
// count widths, request codes, status codes and sequencer states.
// ----------------------------------------------------------------------------
package ags_pkg;

   localparam int MAX_VERTICES = 64;
   localparam int VERTEX_W     = $clog2(MAX_VERTICES);
   localparam int COUNT_W      = $clog2(MAX_VERTICES + 1);
   localparam int OP_W         = 3;
   localparam int STATUS_W     = 2;

   typedef logic [VERTEX_W-1:0]     vertex_type;
   typedef logic [COUNT_W-1:0]      count_type;
   typedef logic [MAX_VERTICES-1:0] row_type;

   typedef enum logic [OP_W-1:0] {
      OP_GROW      = 3'd0,
      OP_ADD_GROW  = 3'd1,
      OP_ADD_EXIST = 3'd2,
      OP_CLEAR     = 3'd3,
      OP_QUERY     = 3'd4,
      OP_FIND      = 3'd5
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_ASYM  = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_LINK_RDA,
      S_LINK_WRA,
      S_LINK_RDB,
      S_LINK_WRB,
      S_CLR_RDA,
      S_CLR_LDA,
      S_CLR_RUN,
      S_CLR_WRA,
      S_FIND_RUN,
      S_QUERY_RD,
      S_QUERY_CHK,
      S_FIN_RD,
      S_OUT
   } state_type;

endpackage

// ===== hw/rtl/ags_if.sv =====
// ----------------------------------------------------------------------------
// ags request and response channels
// Valid/ready channels carrying one request item and one result item of the
// adjacency matrix graph store.
// ----------------------------------------------------------------------------
interface ags_req_if;
   import ags_pkg::*;

   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     req_type;
   vertex_type          vertex_a;
   vertex_type          vertex_b;

   modport source (output valid, req_type, vertex_a, vertex_b, input ready);
   modport sink   (input valid, req_type, vertex_a, vertex_b, output ready);
endinterface

interface ags_rsp_if;
   import ags_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic                adjacent;
   logic                found;
   vertex_type          found_vertex;
   count_type           vertex_count;
   count_type           degree_a;

   modport source (output valid, status, adjacent, found, found_vertex, vertex_count,
                   degree_a, input ready);
   modport sink   (input valid, status, adjacent, found, found_vertex, vertex_count,
                   degree_a, output ready);
endinterface

// ===== hw/rtl/adjacency_matrix_graph_store_unit.sv =====
// ----------------------------------------------------------------------------
// adjacency_matrix_graph_store_unit
// Undirected graph store: bit adjacency matrix, per-vertex degree counters
// and a vertex count, worked on by a small sequencer over one read and one write port.
//
// Usage:
//   req_ch carries one request item (req_type, vertex_a, vertex_b); rsp_ch
//   returns exactly one result item per request. Items move on valid and
//   ready both high at a rising clock edge.
//   req_ch.ready is high only while the sequencer is idle; one request is
//   worked on at a time and the next can be taken in the cycle its result turns valid.
//   The clear and find walks read one row and one degree counter per cycle
//   through the single read port of the matrix and degree memories.
//   The result sits in an output register; the next request is taken while
//   it waits. A new result waits inside until the receiver takes the old one.
//   Reset (synchronous, active high) empties the graph at once through
//   per-row valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
module adjacency_matrix_graph_store_unit (
   input logic       clock,
   input logic       reset,
   ags_req_if.sink   req_ch,
   ags_rsp_if.source rsp_ch
);
   import ags_pkg::*;

   state_type  state_ff, state_in;
   op_type     op_ff, op_in;
   vertex_type a_ff, a_in;
   vertex_type b_ff, b_in;
   count_type  order_ff, order_in;
   status_type status_ff, status_in;
   logic       adj_ff, adj_in;
   logic       found_ff, found_in;
   vertex_type fvert_ff, fvert_in;
   logic       ab_ff, ab_in;
   row_type    rowa_ff, rowa_in;
   count_type  dega_ff, dega_in;
   count_type  cnt_ff, cnt_in;
   logic       p_vld_ff, p_vld_in;
   vertex_type p_idx_ff, p_idx_in;

   row_type    adj_mem [MAX_VERTICES];
   count_type  deg_mem [MAX_VERTICES];
   row_type    vld_ff;
   row_type    rd_row_ff;
   count_type  rd_deg_ff;
   logic       rd_vld_ff;

   vertex_type rd_addr;
   logic       wr_en;
   vertex_type wr_addr;
   row_type    wr_row;
   count_type  wr_deg;
   row_type    cur_row;
   count_type  cur_deg;

   logic       rsp_vld_ff, rsp_vld_in;
   status_type rsp_status_ff, rsp_status_in;
   logic       rsp_adj_ff, rsp_adj_in;
   logic       rsp_found_ff, rsp_found_in;
   vertex_type rsp_fvert_ff, rsp_fvert_in;
   count_type  rsp_count_ff, rsp_count_in;
   count_type  rsp_deg_ff, rsp_deg_in;

   logic       accept;
   logic       rsp_free;
   count_type  a_ext, b_ext, a_plus, b_plus, grow_ab;
   logic       a_oob_max, b_oob_max, a_oob_ord, b_oob_ord;
   logic       scan_more;

   assign accept       = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE);
   assign rsp_free     = !rsp_vld_ff || rsp_ch.ready;

   assign a_ext     = count_type'(a_ff);
   assign b_ext     = count_type'(b_ff);
   assign a_plus    = a_ext + count_type'(1);
   assign b_plus    = b_ext + count_type'(1);
   assign a_oob_max = (a_ext >= count_type'(MAX_VERTICES));
   assign b_oob_max = (b_ext >= count_type'(MAX_VERTICES));
   assign a_oob_ord = (a_ext >= order_ff);
   assign b_oob_ord = (b_ext >= order_ff);
   assign grow_ab   = (order_ff < a_plus) ? a_plus : order_ff;
   assign scan_more = (cnt_ff < order_ff);

   assign cur_row = rd_vld_ff ? rd_row_ff : '0;
   assign cur_deg = rd_vld_ff ? rd_deg_ff : '0;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_DECODE;
         end
         S_DECODE: begin
            case (op_ff)
               OP_GROW:      state_in = S_FIN_RD;
               OP_ADD_GROW:  state_in = (a_ff == b_ff || a_oob_max || b_oob_max) ?
                                        S_FIN_RD : S_LINK_RDA;
               OP_ADD_EXIST: state_in = (a_oob_ord || b_oob_ord) ? S_FIN_RD : S_LINK_RDA;
               OP_CLEAR:     state_in = a_oob_ord ? S_FIN_RD : S_CLR_RDA;
               OP_QUERY:     state_in = (a_oob_ord || b_oob_ord) ? S_FIN_RD : S_QUERY_RD;
               OP_FIND:      state_in = S_FIND_RUN;
               default:      state_in = S_FIN_RD;
            endcase
         end
         S_LINK_RDA:  state_in = S_LINK_WRA;
         S_LINK_WRA:  state_in = S_LINK_RDB;
         S_LINK_RDB:  state_in = S_LINK_WRB;
         S_LINK_WRB:  state_in = S_FIN_RD;
         S_CLR_RDA:   state_in = S_CLR_LDA;
         S_CLR_LDA:   state_in = S_CLR_RUN;
         S_CLR_RUN: begin
            if (!scan_more && !p_vld_ff) state_in = S_CLR_WRA;
         end
         S_CLR_WRA:   state_in = S_FIN_RD;
         S_FIND_RUN: begin
            if ((p_vld_ff && cur_deg == '0) || (!scan_more && !p_vld_ff)) begin
               state_in = S_FIN_RD;
            end
         end
         S_QUERY_RD:  state_in = S_QUERY_CHK;
         S_QUERY_CHK: state_in = S_FIN_RD;
         S_FIN_RD:    state_in = S_OUT;
         S_OUT: begin
            if (rsp_free) state_in = S_IDLE;
         end
         default:     state_in = S_IDLE;
      endcase
   end

   // sequencer outputs and datapath
   always_comb begin
      op_in         = op_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      order_in      = order_ff;
      status_in     = status_ff;
      adj_in        = adj_ff;
      found_in      = found_ff;
      fvert_in      = fvert_ff;
      ab_in         = ab_ff;
      rowa_in       = rowa_ff;
      dega_in       = dega_ff;
      cnt_in        = cnt_ff;
      p_vld_in      = p_vld_ff;
      p_idx_in      = p_idx_ff;
      rd_addr       = a_ff;
      wr_en         = 1'b0;
      wr_addr       = a_ff;
      wr_row        = cur_row;
      wr_deg        = cur_deg;
      rsp_vld_in    = rsp_vld_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_adj_in    = rsp_adj_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_fvert_in  = rsp_fvert_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_deg_in    = rsp_deg_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in     = op_type'(req_ch.req_type);
               a_in      = req_ch.vertex_a;
               b_in      = req_ch.vertex_b;
               status_in = ST_OK;
               adj_in    = 1'b0;
               found_in  = 1'b0;
               fvert_in  = '0;
            end
         end
         S_DECODE: begin
            case (op_ff)
               OP_GROW: begin
                  if (a_oob_max) status_in = ST_RANGE;
                  else           order_in  = grow_ab;
               end
               OP_ADD_GROW: begin
                  if (a_ff != b_ff) begin
                     if (a_oob_max || b_oob_max) status_in = ST_RANGE;
                     else order_in = (grow_ab < b_plus) ? b_plus : grow_ab;
                  end
               end
               OP_ADD_EXIST, OP_QUERY: begin
                  if (a_oob_ord || b_oob_ord) status_in = ST_RANGE;
               end
               OP_CLEAR: begin
                  if (a_oob_ord) status_in = ST_RANGE;
               end
               OP_FIND: begin
                  cnt_in   = '0;
                  p_vld_in = 1'b0;
               end
               default: ;
            endcase
         end
         S_LINK_WRA: begin
            ab_in = cur_row[b_ff];
            if (!cur_row[b_ff]) begin
               wr_en   = 1'b1;
               wr_addr = a_ff;
               wr_row  = cur_row | (row_type'(1) << b_ff);
               wr_deg  = cur_deg + count_type'(1);
            end
         end
         S_LINK_RDB: rd_addr = b_ff;
         S_LINK_WRB: begin
            if (!cur_row[a_ff]) begin
               wr_en   = 1'b1;
               wr_addr = b_ff;
               wr_row  = cur_row | (row_type'(1) << a_ff);
               wr_deg  = cur_deg + count_type'(1);
            end
            if (op_ff == OP_ADD_GROW && ab_ff != cur_row[a_ff]) status_in = ST_ASYM;
         end
         S_CLR_LDA: begin
            rowa_in  = cur_row;
            dega_in  = cur_deg;
            cnt_in   = '0;
            p_vld_in = 1'b0;
         end
         S_CLR_RUN, S_FIND_RUN: begin
            rd_addr  = cnt_ff[VERTEX_W-1:0];
            p_vld_in = scan_more;
            p_idx_in = cnt_ff[VERTEX_W-1:0];
            if (scan_more) cnt_in = cnt_ff + count_type'(1);
            if (state_ff == S_CLR_RUN) begin
               if (p_vld_ff && p_idx_ff != a_ff && cur_row[a_ff]) begin
                  wr_en   = 1'b1;
                  wr_addr = p_idx_ff;
                  wr_row  = cur_row & ~(row_type'(1) << a_ff);
                  wr_deg  = (cur_deg == '0) ? '0 : cur_deg - count_type'(1);
               end
               if (p_vld_ff && rowa_ff[p_idx_ff] && dega_ff != '0) begin
                  dega_in = dega_ff - count_type'(1);
               end
            end else if (p_vld_ff && cur_deg == '0) begin
               found_in = 1'b1;
               fvert_in = p_idx_ff;
               p_vld_in = 1'b0;
            end
         end
         S_CLR_WRA: begin
            wr_en   = 1'b1;
            wr_addr = a_ff;
            wr_row  = '0;
            wr_deg  = dega_ff;
         end
         S_QUERY_CHK: adj_in = (a_ff == b_ff) || cur_row[b_ff];
         S_OUT: begin
            if (rsp_free) begin
               rsp_vld_in    = 1'b1;
               rsp_status_in = status_ff;
               rsp_adj_in    = adj_ff;
               rsp_found_in  = found_ff;
               rsp_fvert_in  = fvert_ff;
               rsp_count_in  = order_ff;
               rsp_deg_in    = a_oob_max ? '0 : cur_deg;
            end
         end
         default: ;
      endcase
   end

   // matrix rows and degree counters
   always_ff @(posedge clock) begin
      if (wr_en) begin
         adj_mem[wr_addr] <= wr_row;
         deg_mem[wr_addr] <= wr_deg;
      end
      rd_row_ff <= adj_mem[rd_addr];
      rd_deg_ff <= deg_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         order_ff   <= '0;
         p_vld_ff   <= 1'b0;
         vld_ff     <= '0;
         rd_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         order_ff   <= order_in;
         p_vld_ff   <= p_vld_in;
         if (wr_en) vld_ff[wr_addr] <= 1'b1;
         rd_vld_ff  <= vld_ff[rd_addr];
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      status_ff     <= status_in;
      adj_ff        <= adj_in;
      found_ff      <= found_in;
      fvert_ff      <= fvert_in;
      ab_ff         <= ab_in;
      rowa_ff       <= rowa_in;
      dega_ff       <= dega_in;
      cnt_ff        <= cnt_in;
      p_idx_ff      <= p_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_adj_ff    <= rsp_adj_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_fvert_ff  <= rsp_fvert_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_deg_ff    <= rsp_deg_in;
   end

   assign rsp_ch.valid        = rsp_vld_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.adjacent     = rsp_adj_ff;
   assign rsp_ch.found        = rsp_found_ff;
   assign rsp_ch.found_vertex = rsp_fvert_ff;
   assign rsp_ch.vertex_count = rsp_count_ff;
   assign rsp_ch.degree_a     = rsp_deg_ff;

   a_order_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> order_ff >= $past(order_ff))
      else $error("vertex count decreased");

   a_order_bound: assert property (@(posedge clock) disable iff (reset)
      order_ff <= count_type'(MAX_VERTICES))
      else $error("vertex count beyond capacity");

   a_found_below_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_found_ff) |-> count_type'(rsp_fvert_ff) < rsp_count_ff)
      else $error("isolated vertex outside the graph");

   a_scan_in_graph: assert property (@(posedge clock) disable iff (reset)
      p_vld_ff |-> count_type'(p_idx_ff) < order_ff)
      else $error("walk index outside the graph");

endmodule
